// ===== src/pcsq_pkg.sv =====
// Shared types, widths, constants and the scale table of the pitch CV scale quantizer.
package pcsq_pkg;

   // channel and field widths
   localparam int REQ_DATA_W  = 64;
   localparam int REQ_USER_W  = 4;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int LEVEL_W     = 20;
   localparam int PITCH_OUT_W = 21;
   localparam int NOTE_W      = 11;
   localparam int PULSE_W     = 10;
   localparam int SCALE_W     = 4;
   localparam int SEMI_W      = 4;

   // semitone index offset: 100 octaves below 0 V
   localparam int SEMI_OFFSET = 1200;
   localparam logic [NOTE_W-1:0] NOTE_MAX = '1;

   localparam logic [PULSE_W-1:0] PULSE_RESET = PULSE_W'(512);

   // idx / 12 for an 11-bit index: (idx * 2731) >> 15
   localparam int RECIP12       = 2731;
   localparam int RECIP12_SHIFT = 15;
   localparam int OCTAVE_W      = 8;

   localparam int NUM_SCALES     = 11;
   localparam int SEMIS_PER_OCT  = 12;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCALE_SELECT = 2'd0,
      CSR_USE_TRIGGER  = 2'd1,
      CSR_PULSE_LENGTH = 2'd2
   } csr_index_type;

   typedef logic [SEMI_W-1:0] scale_row_type [SEMIS_PER_OCT];

   // each row maps a semitone within the octave down to the nearest note of the scale
   localparam scale_row_type SCALE_ROM [NUM_SCALES] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11}, // chromatic
      '{4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd4, 4'd6, 4'd6, 4'd8, 4'd8, 4'd10, 4'd10}, // whole tone
      '{4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd5, 4'd5, 4'd7, 4'd7, 4'd9, 4'd9, 4'd11},  // major
      '{4'd0, 4'd0, 4'd2, 4'd3, 4'd3, 4'd5, 4'd5, 4'd7, 4'd8, 4'd8, 4'd10, 4'd10}, // minor
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd4, 4'd4, 4'd4, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7},   // major chord
      '{4'd0, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7},   // minor chord
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd4, 4'd4, 4'd4, 4'd7, 4'd7, 4'd7, 4'd7, 4'd11},  // major 7
      '{4'd0, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3, 4'd7, 4'd7, 4'd7, 4'd10, 4'd10}, // minor 7
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd4, 4'd4, 4'd4, 4'd7, 4'd7, 4'd9, 4'd9, 4'd9},   // major 6
      '{4'd0, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3, 4'd7, 4'd7, 4'd9, 4'd9, 4'd9},   // minor 6
      '{4'd0, 4'd0, 4'd2, 4'd2, 4'd2, 4'd5, 4'd5, 4'd7, 4'd7, 4'd9, 4'd9, 4'd9}    // pentatonic
   };

   // rows past the table act as chromatic
   function automatic logic [SEMI_W-1:0] scale_step(input logic [SCALE_W-1:0] row,
                                                    input logic [SEMI_W-1:0]  semi);
      logic [SEMI_W-1:0] step;
      step = semi;
      if (row < SCALE_W'(NUM_SCALES) && semi < SEMI_W'(SEMIS_PER_OCT)) begin
         step = SCALE_ROM[row][semi];
      end
      return step;
   endfunction

endpackage

// ===== src/pitch_cv_scale_quantizer.sv =====
// Top level of the per-voice 1V/octave pitch CV scale quantizer.
//
// Usage:
//   req channel: one beat per voice sample. req_tuser carries the voice index,
//   req_tdata the pitch, trigger level and transpose voltages in signed Q.FRAC_BITS.
//   rsp channel: one beat per request beat, in order, with the quantized and
//   transposed pitch and the new-note trigger flag.
//   csr channel: register index and data; always ready. Write it only while the
//   block holds no request beats.
// Path: an accepted beat passes the input register, stage 1, stage 2 and the
//   output register before it shows on rsp.
// Throughput: one beat per cycle unless rsp stalls. Per-voice state is read and
//   written in the same cycle of one stage, so same-voice beats may run back to back.
// Reset: empties the pipeline, clears every voice's held note, trigger arm and
//   pulse counter, and returns the registers to chromatic, free mode, 512.
// Stall: a held rsp beat stays put while earlier stages keep filling; the block
//   buffers up to four beats before req_tready drops.
module pitch_cv_scale_quantizer
   import pcsq_pkg::*;
#(
   parameter int VOICES    = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // pitch_in[19:0], trigger_in[39:20],
                                               // transpose_in[59:40], zero [63:60]
   input  logic [REQ_USER_W-1:0]  req_tuser,   // voice[3:0]
   // response
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // pitch_out[20:0], trigger_out[21],
                                               // zero [23:22]
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // voice index width and datapath widths that follow from FRAC_BITS
   localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int PW    = LEVEL_W + 4;                    // level times 12
   localparam int TSW   = PW + 1 - FRAC_BITS;             // transpose in semitones
   localparam int NSW   = ((TSW > NOTE_W + 1) ? TSW : NOTE_W + 1) + 1;
   localparam int K     = FRAC_BITS - 2;                  // 2^F / 12 = 2^K / 3
   localparam int MAGW  = NSW + FRAC_BITS;
   localparam int RW    = 2 * NSW + 1;

   localparam logic [NSW:0]      RECIP3 = (NSW+1)'((2 ** (NSW + 1)) / 3 + 1);
   localparam logic [MAGW-1:0]   ROUND1 = MAGW'((2 ** K + 1) / 3);
   localparam logic [MAGW-1:0]   ROUND2 = MAGW'((2 ** (K + 1) + 1) / 3);
   localparam logic [MAGW-1:0]   POS_LIMIT = MAGW'(2 ** (PITCH_OUT_W - 1) - 1);
   localparam logic [MAGW-1:0]   NEG_LIMIT = MAGW'(2 ** (PITCH_OUT_W - 1));
   localparam logic signed [PW+1:0] HALF_VOLT = (PW+2)'(1) <<< (FRAC_BITS - 1);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic               mode_ff,  mode_in;
   logic [PULSE_W-1:0] plen_ff,  plen_in;

   assign csr_ready = 1'b1;

   always_comb begin
      scale_in = scale_ff;
      mode_in  = mode_ff;
      plen_in  = plen_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCALE_SELECT: scale_in = csr_data[SCALE_W-1:0];
            CSR_USE_TRIGGER:  mode_in  = csr_data[0];
            CSR_PULSE_LENGTH: plen_in  = csr_data[PULSE_W-1:0];
            default:          ;  // index past the list: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
         mode_ff  <= 1'b0;
         plen_ff  <= PULSE_RESET;
      end else begin
         scale_ff <= scale_in;
         mode_ff  <= mode_in;
         plen_ff  <= plen_in;
      end
   end

   // ------------------------------------------------------------------
   // pipeline flow: each stage loads when empty or when the next one moves
   // ------------------------------------------------------------------
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic out_load, s2_load, s1_load, s0_load;
   logic req_beat;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign s2_load    = !s2_valid_ff  || out_load;
   assign s1_load    = !s1_valid_ff  || s2_load;
   assign s0_load    = !s0_valid_ff  || s1_load;
   assign req_tready = s0_load;
   assign req_beat   = req_tvalid && s0_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s0_load)  s0_valid_ff  <= req_tvalid;
         if (s1_load)  s1_valid_ff  <= s0_valid_ff;
         if (s2_load)  s2_valid_ff  <= s1_valid_ff;
         if (out_load) out_valid_ff <= s2_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 0: input register
   // ------------------------------------------------------------------
   logic [REQ_USER_W-1:0]     s0_voice_ff;
   logic signed [LEVEL_W-1:0] s0_pitch_ff, s0_trig_ff, s0_trans_ff;

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s0_voice_ff <= req_tuser;
         s0_pitch_ff <= req_tdata[LEVEL_W-1:0];
         s0_trig_ff  <= req_tdata[2*LEVEL_W-1:LEVEL_W];
         s0_trans_ff <= req_tdata[3*LEVEL_W-1:2*LEVEL_W];
      end
   end

   // ------------------------------------------------------------------
   // stage 0 -> 1: semitone index, transpose in semitones, trigger compares
   // ------------------------------------------------------------------
   logic signed [PW-1:0]   pitch_x12, pitch_semi, trans_x12, trans_floor, trans_semi;
   logic signed [PW:0]     idx_wide;
   logic [NOTE_W-1:0]      s1_idx_in;
   logic [VW-1:0]          s1_voice_in;
   logic signed [PW+1:0]   trig_wide;

   assign pitch_x12  = PW'(s0_pitch_ff) * PW'(12);
   assign pitch_semi = pitch_x12 >>> FRAC_BITS;              // floor
   assign idx_wide   = (PW+1)'(pitch_semi) + (PW+1)'(SEMI_OFFSET);

   // saturate the index to the note range
   always_comb begin
      if (idx_wide < 0) begin
         s1_idx_in = '0;
      end else if (idx_wide > (PW+1)'(NOTE_MAX)) begin
         s1_idx_in = NOTE_MAX;
      end else begin
         s1_idx_in = idx_wide[NOTE_W-1:0];
      end
   end

   // transpose truncates toward zero: bump the floor up for negative inexact values
   assign trans_x12   = PW'(s0_trans_ff) * PW'(12);
   assign trans_floor = trans_x12 >>> FRAC_BITS;
   assign trans_semi  = (trans_x12 < 0 && trans_x12[FRAC_BITS-1:0] != '0)
                        ? trans_floor + PW'(1) : trans_floor;

   // an out-of-range voice uses the last voice
   assign s1_voice_in = ({28'd0, s0_voice_ff} >= 32'(VOICES)) ? VW'(VOICES - 1)
                                                              : VW'(s0_voice_ff);
   assign trig_wide   = (PW+2)'(s0_trig_ff);

   logic [VW-1:0]          s1_voice_ff;
   logic [NOTE_W-1:0]      s1_idx_ff;
   logic signed [TSW-1:0]  s1_trans_ff;
   logic                   s1_above_ff, s1_below_ff;

   always_ff @(posedge clock) begin
      if (s1_load && s0_valid_ff) begin
         s1_voice_ff <= s1_voice_in;
         s1_idx_ff   <= s1_idx_in;
         s1_trans_ff <= TSW'(trans_semi);
         s1_above_ff <= trig_wide > HALF_VOLT;
         s1_below_ff <= trig_wide < HALF_VOLT;
      end
   end

   // ------------------------------------------------------------------
   // stage 1 -> 2: per-voice state, scale lookup, note sum
   // ------------------------------------------------------------------
   logic [NOTE_W-1:0]  held_ff  [VOICES];
   logic               armed_ff [VOICES];
   logic [PULSE_W-1:0] count_ff [VOICES];

   logic [NOTE_W-1:0]  held_rd,  held_in,  held_trig;
   logic               armed_rd, armed_in;
   logic [PULSE_W-1:0] count_rd, count_in, count_trig;
   logic               rise;
   logic [NOTE_W-1:0]  quant_src, quant_note;
   logic               tout_in;
   logic               state_write;

   function automatic logic [NOTE_W-1:0] quantize(input logic [SCALE_W-1:0] row,
                                                  input logic [NOTE_W-1:0]  idx);
      logic [NOTE_W+11:0]   prod;
      logic [OCTAVE_W-1:0]  octave;
      logic [NOTE_W-1:0]    base;
      logic [NOTE_W-1:0]    rem;
      prod   = (NOTE_W+12)'(idx) * (NOTE_W+12)'(RECIP12);
      octave = prod[RECIP12_SHIFT +: OCTAVE_W];
      base   = NOTE_W'(octave) * NOTE_W'(SEMIS_PER_OCT);
      rem    = idx - base;
      return base + NOTE_W'(scale_step(row, rem[SEMI_W-1:0]));
   endfunction

   assign held_rd  = held_ff[s1_voice_ff];
   assign armed_rd = armed_ff[s1_voice_ff];
   assign count_rd = count_ff[s1_voice_ff];

   // triggered mode: a rise above half a volt samples the raw index
   assign rise       = !armed_rd && s1_above_ff;
   assign held_trig  = rise ? s1_idx_ff : held_rd;
   assign count_trig = rise ? plen_ff   : count_rd;

   // one quantizer: raw index in free mode, held note in triggered mode
   assign quant_src  = mode_ff ? held_trig : s1_idx_ff;
   assign quant_note = quantize(scale_ff, quant_src);

   always_comb begin
      held_in  = held_rd;
      armed_in = armed_rd;
      count_in = count_rd;
      tout_in  = 1'b0;
      if (!mode_ff) begin
         if (held_rd != quant_note) begin
            held_in  = quant_note;
            count_in = plen_ff;
            tout_in  = 1'b1;
         end else if (count_rd != '0) begin
            count_in = count_rd - PULSE_W'(1);
            tout_in  = 1'b1;
         end
      end else begin
         held_in = held_trig;
         if (rise) begin
            armed_in = 1'b1;
         end else if (armed_rd && s1_below_ff) begin
            armed_in = 1'b0;
         end
         count_in = count_trig;
         if (count_trig != '0) begin
            count_in = count_trig - PULSE_W'(1);
            tout_in  = 1'b1;
         end
      end
   end

   assign state_write = s1_valid_ff && s2_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICES; v++) begin
            held_ff[v]  <= '0;
            armed_ff[v] <= 1'b0;
            count_ff[v] <= '0;
         end
      end else if (state_write) begin
         held_ff[s1_voice_ff]  <= held_in;
         armed_ff[s1_voice_ff] <= armed_in;
         count_ff[s1_voice_ff] <= count_in;
      end
   end

   logic signed [NSW-1:0] note_in;
   logic signed [NSW-1:0] s2_note_ff;
   logic                  s2_tout_ff;

   // in free mode the held note equals the quantized note after the update
   assign note_in = $signed(NSW'(quant_note)) + NSW'(s1_trans_ff) - NSW'(SEMI_OFFSET);

   always_ff @(posedge clock) begin
      if (state_write) begin
         s2_note_ff <= note_in;
         s2_tout_ff <= tout_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2 -> out: note * 2^F / 12, rounded to nearest, saturated
   // ------------------------------------------------------------------
   logic              note_neg;
   logic [NSW-1:0]    note_mag, third, rem3;
   logic [RW-1:0]     third_prod;
   logic [MAGW-1:0]   round_add, scaled;
   logic signed [PITCH_OUT_W-1:0] pitch_in_res;

   assign note_neg   = s2_note_ff[NSW-1];
   assign note_mag   = note_neg ? NSW'(-s2_note_ff) : NSW'(s2_note_ff);
   assign third_prod = RW'(note_mag) * RW'(RECIP3);
   assign third      = NSW'(third_prod >> (NSW + 1));
   assign rem3       = note_mag - NSW'(third * NSW'(3));

   // |note| = 3a + b, so |note| * 2^K / 3 rounds to a * 2^K + round(b * 2^K / 3)
   always_comb begin
      unique case (rem3[1:0])
         2'd1:    round_add = ROUND1;
         2'd2:    round_add = ROUND2;
         default: round_add = '0;
      endcase
   end

   assign scaled = (MAGW'(third) << K) + round_add;

   always_comb begin
      if (note_neg) begin
         if (scaled > NEG_LIMIT) begin
            pitch_in_res = $signed(PITCH_OUT_W'(NEG_LIMIT));
         end else begin
            pitch_in_res = -$signed(PITCH_OUT_W'(scaled));
         end
      end else begin
         if (scaled > POS_LIMIT) begin
            pitch_in_res = $signed(PITCH_OUT_W'(POS_LIMIT));
         end else begin
            pitch_in_res = $signed(PITCH_OUT_W'(scaled));
         end
      end
   end

   logic signed [PITCH_OUT_W-1:0] out_pitch_ff;
   logic                          out_tout_ff;

   always_ff @(posedge clock) begin
      if (out_load && s2_valid_ff) begin
         out_pitch_ff <= pitch_in_res;
         out_tout_ff  <= s2_tout_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - PITCH_OUT_W - 1)'(0), out_tout_ff, out_pitch_ff};

endmodule

// ===== src/pcsq_checker.sv =====
// Port-level checker for the pitch CV scale quantizer, bound to its top level.
module pcsq_checker
   import pcsq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // beats taken in but not yet handed out
   logic [2:0] pend_ff, pend_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;
   assign pend_in  = pend_ff + 3'(req_beat) - 3'(rsp_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // reset empties the output stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // no response without a pending request
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 3'd0)
      else $error("rsp beat with no request pending");

   // never more beats in flight than the four pipeline registers hold
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd4)
      else $error("more than four beats in flight");

   // an empty pipeline presents the result after all four registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_beat && pend_ff == 3'd0 |-> ##4 rsp_tvalid)
      else $error("result late on an empty pipeline");

endmodule

bind pitch_cv_scale_quantizer pcsq_checker u_pcsq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/pitch_cv_scale_quantizer_tb.sv =====
// Self-checking testbench for the pitch CV scale quantizer: directed corners, then random phases.
`timescale 1ns / 1ps

module pitch_cv_scale_quantizer_tb;
   import pcsq_pkg::*;

   // fixed-point and note constants of the quantizer
   localparam int     FRAC        = 16;
   localparam int     SEMIS       = 12;
   localparam int     NUM_ROWS    = 11;
   localparam longint INDEX_BASE  = 1200;
   localparam longint INDEX_MAX   = 2047;
   localparam longint OUT_MAX     = 1048575;
   localparam longint OUT_MIN     = -1048576;
   localparam int     LEVEL_MAX   = 524287;
   localparam int     LEVEL_MIN   = -524288;
   localparam int     HALF_VOLT   = 32768;    // 0.5 V in Q.16
   localparam int     SEMITONE_V  = 5462;     // a hair over 1/12 V
   localparam int     DRAIN_CYCLES = 8;       // the pipeline has four registers
   localparam int     PHASES      = 16;
   localparam int     PHASE_ITEMS = 66;

   // scale rows: semitone within the octave -> nearest allowed note at or below it
   localparam int SNAP_TABLE [NUM_ROWS][SEMIS] = '{
      '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11},
      '{0, 0, 2, 2, 4, 4, 6, 6, 8, 8, 10, 10},
      '{0, 0, 2, 2, 4, 5, 5, 7, 7, 9, 9, 11},
      '{0, 0, 2, 3, 3, 5, 5, 7, 8, 8, 10, 10},
      '{0, 0, 0, 0, 4, 4, 4, 7, 7, 7, 7, 7},
      '{0, 0, 0, 3, 3, 3, 3, 7, 7, 7, 7, 7},
      '{0, 0, 0, 0, 4, 4, 4, 7, 7, 7, 7, 11},
      '{0, 0, 0, 3, 3, 3, 3, 7, 7, 7, 10, 10},
      '{0, 0, 0, 0, 4, 4, 4, 7, 7, 9, 9, 9},
      '{0, 0, 0, 3, 3, 3, 3, 7, 7, 9, 9, 9},
      '{0, 0, 2, 2, 2, 5, 5, 7, 7, 9, 9, 9}
   };

   typedef struct {
      logic signed [PITCH_OUT_W-1:0] pitch;
      logic                          gate;
   } note_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // pitch_in[19:0], trigger_in[39:20],
                                        // transpose_in[59:40], zero [63:60]
   logic [REQ_USER_W-1:0]  req_tuser;   // voice[3:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;   // pitch_out[20:0], trigger_out[21], zero [23:22]
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // shadow of the control registers and of every voice's state
   logic [SCALE_W-1:0]     scale_sel;
   logic                   trig_mode;
   logic [PULSE_W-1:0]     pulse_len;
   logic [NOTE_W-1:0]      held [16];
   logic                   armed [16];
   logic [PULSE_W-1:0]     pulse_left [16];

   note_result_type        pending_notes [$];
   int unsigned            errors = 0;
   bit                     eager = 1'b0;      // no idling on either side while set
   int                     last_pitch [16];

   always #5 clock = ~clock;

   pitch_cv_scale_quantizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Snap an 11-bit semitone index down onto the selected scale.
   // Rows past the table behave as chromatic.
   function automatic logic [NOTE_W-1:0] snap_to_scale(input logic [NOTE_W-1:0] semis);
      int row;
      int octave;
      int semi_pos;
      row      = (scale_sel < NUM_ROWS) ? int'(scale_sel) : 0;
      octave   = int'(semis) / SEMIS;
      semi_pos = int'(semis) % SEMIS;
      return NOTE_W'(octave * SEMIS + SNAP_TABLE[row][semi_pos]);
   endfunction

   // Advance one voice by one sample and return the beat the block should emit.
   function automatic note_result_type quantize_step(input logic [3:0]          voice,
                                                     input logic signed [19:0]  pitch,
                                                     input logic signed [19:0]  trig,
                                                     input logic signed [19:0]  trans);
      longint       semi_idx;
      longint       note;
      longint       scaled;
      longint       rounded;
      logic [NOTE_W-1:0] idx;
      logic [NOTE_W-1:0] fresh;
      note_result_type res;
      res.gate = 1'b0;

      // arithmetic shift of a signed product floors toward minus infinity
      semi_idx = INDEX_BASE + ((longint'(pitch) * SEMIS) >>> FRAC);
      if (semi_idx < 0) semi_idx = 0;
      if (semi_idx > INDEX_MAX) semi_idx = INDEX_MAX;
      idx = semi_idx[NOTE_W-1:0];

      if (!trig_mode) begin
         // free mode: a new quantized note restarts the pulse, one sample longer
         fresh = snap_to_scale(idx);
         if (held[voice] != fresh) begin
            held[voice]       = fresh;
            pulse_left[voice] = pulse_len;
            res.gate          = 1'b1;
         end else if (pulse_left[voice] != 0) begin
            pulse_left[voice] = pulse_left[voice] - 1'b1;
            res.gate          = 1'b1;
         end
         note = longint'(held[voice]);
      end else begin
         // triggered mode: rise strictly above 0.5 V, re-arm strictly below it;
         // the raw index is held and snapped on the way out
         if (!armed[voice] && longint'(trig) > HALF_VOLT) begin
            armed[voice]      = 1'b1;
            held[voice]       = idx;
            pulse_left[voice] = pulse_len;
         end else if (armed[voice] && longint'(trig) < HALF_VOLT) begin
            armed[voice] = 1'b0;
         end
         if (pulse_left[voice] != 0) begin
            pulse_left[voice] = pulse_left[voice] - 1'b1;
            res.gate          = 1'b1;
         end
         note = longint'(snap_to_scale(held[voice]));
      end

      // transpose truncates toward zero
      scaled = longint'(trans) * SEMIS;
      note   = note + ((scaled >= 0) ? (scaled >>> FRAC) : -((-scaled) >>> FRAC)) - INDEX_BASE;

      // divide by 12, round half away from zero, saturate
      scaled  = note * (longint'(1) << FRAC);
      rounded = (scaled >= 0) ? (scaled + 6) / SEMIS : -((-scaled + 6) / SEMIS);
      if (rounded > OUT_MAX) rounded = OUT_MAX;
      if (rounded < OUT_MIN) rounded = OUT_MIN;
      res.pitch = rounded[PITCH_OUT_W-1:0];
      return res;
   endfunction

   function automatic void clear_model();
      scale_sel = '0;
      trig_mode = 1'b0;
      pulse_len = PULSE_RESET;
      for (int v = 0; v < 16; v++) begin
         held[v]       = '0;
         armed[v]      = 1'b0;
         pulse_left[v] = '0;
         last_pitch[v] = 0;
      end
   endfunction

   // signed value drawn evenly from [lo, hi]
   function automatic int rand_level(input int lo, input int hi);
      return int'($urandom_range(hi - lo)) + lo;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Offer one voice sample after a random gap and hold it until accepted.
   // Leave tvalid high on return so a zero gap runs beats back to back.
   task automatic play_sample(input logic [3:0] voice, input int pitch,
                              input int trig, input int trans);
      int unsigned gap;
      gap = eager ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= voice;
      req_tdata  <= REQ_DATA_W'({4'b0, trans[19:0], trig[19:0], pitch[19:0]});
      do @(posedge clock); while (!req_tready);
      pending_notes.push_back(quantize_step(voice, pitch[19:0], trig[19:0], trans[19:0]));
   endtask

   // Drop tvalid and hold until every beat in flight has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_notes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one control register once the block is idle; mirror it in the shadow.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SCALE_SELECT: scale_sel = val[SCALE_W-1:0];
         CSR_USE_TRIGGER:  trig_mode = val[0];
         CSR_PULSE_LENGTH: pulse_len = val[PULSE_W-1:0];
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls, compare each beat with the oldest prediction
   // ---------------------------------------------------------------------
   initial begin : rsp_monitor
      note_result_type want;
      note_result_type got;
      int unsigned     hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            got.pitch = rsp_tdata[PITCH_OUT_W-1:0];
            got.gate  = rsp_tdata[PITCH_OUT_W];
            if (pending_notes.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat: expected none, actual pitch_out %0d trigger_out %0b",
                        $time, got.pitch, got.gate);
            end else begin
               want = pending_notes.pop_front();
               if (got.pitch !== want.pitch) begin
                  errors++;
                  $display("%0t: pitch_out mismatch: expected %0d, actual %0d",
                           $time, want.pitch, got.pitch);
               end
               if (got.gate !== want.gate) begin
                  errors++;
                  $display("%0t: trigger_out mismatch: expected %0b, actual %0b",
                           $time, want.gate, got.gate);
               end
            end
            hold = eager ? 0 : $urandom_range(0, 4);
         end else if (hold != 0) begin
            hold--;
         end
         rsp_tready <= !reset && hold == 0;
      end
   end

   // ---------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------

   // Reset defaults: chromatic, free mode, 512-sample pulses. Hit the field extremes,
   // floor of a negative pitch and truncation of the transpose on both sides of zero.
   task automatic test_free_mode_edges();
      play_sample(4'd0, 0, 0, 0);                          // first note: pulse starts
      play_sample(4'd0, 0, 0, 0);                          // same note: pulse continues
      play_sample(4'd15, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
      play_sample(4'd15, LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
      play_sample(4'd3, -1, -1, -1);                       // floors to one semitone down
      play_sample(4'd3, 1, 0, SEMITONE_V);                 // transpose +1 semitone
      play_sample(4'd3, 1, 0, -SEMITONE_V);                // transpose -1 semitone
   endtask

   // Pentatonic snapping, then rows past the table that must act as chromatic.
   task automatic test_scale_rows();
      write_reg(CSR_SCALE_SELECT, 10'd10);
      play_sample(4'd4, 4 * SEMITONE_V, 0, 0);
      write_reg(CSR_SCALE_SELECT, 10'd11);
      play_sample(4'd4, 4 * SEMITONE_V, 0, 0);
      write_reg(CSR_SCALE_SELECT, 10'd15);
      play_sample(4'd4, 3 * SEMITONE_V, 0, 0);
   endtask

   // Triggered mode: an untouched voice saturates low, the threshold itself is
   // neither a rise nor a re-arm, and a 3-sample pulse runs out.
   task automatic test_trigger_edges();
      write_reg(CSR_USE_TRIGGER, 10'd1);
      write_reg(CSR_PULSE_LENGTH, 10'd3);
      play_sample(4'd6, 0, 0, 0);
      play_sample(4'd5, 10000, HALF_VOLT - 1, 0);
      play_sample(4'd5, 10000, HALF_VOLT + 1, 0);          // rise
      play_sample(4'd5, 30000, HALF_VOLT, 0);
      play_sample(4'd5, 30000, HALF_VOLT, 0);
      play_sample(4'd5, 30000, HALF_VOLT, 0);              // pulse over
      play_sample(4'd5, 30000, HALF_VOLT - 1, 0);          // re-arm
      play_sample(4'd5, 30000, LEVEL_MAX, 0);              // rise again
   endtask

   // Zero pulse length in both modes; switching mode keeps the held note.
   task automatic test_zero_pulse();
      write_reg(CSR_PULSE_LENGTH, 10'd0);
      play_sample(4'd7, 5000, HALF_VOLT + 1, 0);           // rise without a pulse
      write_reg(CSR_USE_TRIGGER, 10'd0);
      play_sample(4'd7, 5000, 0, 0);                       // note unchanged
      play_sample(4'd7, -60000, 0, 0);                     // change: one-sample pulse
      play_sample(4'd7, -60000, 0, 0);
   endtask

   // ---------------------------------------------------------------------
   // Random phases
   // ---------------------------------------------------------------------

   // Each phase walks a new register setting. Most beats go to a few voices and
   // mostly repeat a pitch, so pulses run out and triggers see clean low/high runs.
   task automatic test_random_phases();
      int          p;
      int          i;
      int          base;
      int          span;
      int          v;
      int          pitch;
      int          trig;
      int          trans;
      logic [9:0]  plen;
      for (p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 9))
            0:       plen = '0;
            1, 2, 3: plen = 10'($urandom_range(1, 8));
            4:       plen = PULSE_RESET;
            5:       plen = 10'($urandom_range(0, 1023));
            default: plen = 10'($urandom_range(2, 40));
         endcase
         // force the pulse extremes early on
         if (p == 0) plen = 10'd1023;
         if (p == 1) plen = 10'd1;
         write_reg(CSR_SCALE_SELECT, p[9:0]);
         write_reg(CSR_USE_TRIGGER, 10'($urandom_range(0, 1)));
         write_reg(CSR_PULSE_LENGTH, plen);
         eager = ($urandom_range(0, 3) == 0);
         base  = $urandom_range(0, 15);
         span  = $urandom_range(0, 3);

         for (i = 0; i < PHASE_ITEMS; i++) begin
            // pause the sender until all results are back
            if (i == PHASE_ITEMS / 2 && (p % 4 == 0 || $urandom_range(0, 3) == 0)) wait_idle();

            if ($urandom_range(0, 9) < 8) v = (base + $urandom_range(0, span)) % 16;
            else                          v = $urandom_range(0, 15);

            case ($urandom_range(0, 9))
               6:       pitch = $urandom;
               7:       pitch = (rand_level(-96, 95) * 65536) / SEMIS + rand_level(-2, 2);
               8: begin
                  case ($urandom_range(0, 3))
                     0:       pitch = LEVEL_MIN;
                     1:       pitch = LEVEL_MAX;
                     2:       pitch = 0;
                     default: pitch = -1;
                  endcase
               end
               9:       pitch = last_pitch[v] + rand_level(-12000, 12000);
               default: pitch = last_pitch[v];
            endcase
            pitch = int'(signed'(pitch[19:0]));
            last_pitch[v] = pitch;

            case ($urandom_range(0, 9))
               0, 1, 2, 3: trig = rand_level(LEVEL_MIN, HALF_VOLT - 1);
               8:          trig = HALF_VOLT;
               9:          trig = $urandom;
               default:    trig = rand_level(HALF_VOLT + 1, LEVEL_MAX);
            endcase

            case ($urandom_range(0, 9))
               4, 5, 6: trans = $urandom;
               7:       trans = $urandom_range(0, 1) ? LEVEL_MAX : LEVEL_MIN;
               8, 9:    trans = rand_level(-6, 6) * SEMITONE_V;
               default: trans = 0;
            endcase

            play_sample(v[3:0], pitch, trig, trans);
         end
      end
      eager = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence: reset once, run each test, drain, report
   // ---------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_SCALE_SELECT;
      csr_data   <= '0;
      clear_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_free_mode_edges();
      test_scale_rows();
      test_trigger_edges();
      test_zero_pulse();
      test_random_phases();

      // let the last beats drain and give stray beats a chance to show up
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_notes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pcsq_pkg.sv
src/pitch_cv_scale_quantizer.sv
src/pcsq_checker.sv
tb/pitch_cv_scale_quantizer_tb.sv
